// File: rtl/tfs_pkg.sv
`timescale 1ns / 1ps

package tfs_pkg;

	// fixed field widths
	localparam int WIDTH_W    = 14;
	localparam int RES_W      = 13;
	localparam int POS_W      = 16;
	localparam int TAG_W      = 16;
	localparam int PIX_W      = 14;
	localparam int WEIGHT_W   = 28;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 2 * POS_W + TAG_W;
	localparam int OUT_DATA_W = 2 * PIX_W + WEIGHT_W + TAG_W;

	// parameter defaults
	localparam int DEF_MAX_RADIUS = 3;
	localparam int DEF_FRAC_BITS  = 12;

	// resolution limits and reset values
	localparam logic [RES_W-1:0] RES_MAX   = 13'd4096;
	localparam logic [RES_W-1:0] RES_RESET = 13'd1024;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_WIDTH = 2'd0,
		REG_RES_X        = 2'd1,
		REG_RES_Y        = 2'd2
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOC_X,
		ST_LOC_Y,
		ST_EMIT
	} state_t;

endpackage

// File: rtl/triangle_filter_splatter_top.sv
`timescale 1ns / 1ps

// Tent filter splatter: each sample request (normalized x/y position and a tag) is scaled
// by the image resolution and spread over the (2R+1)^2 pixels around its nearest pixel,
// R = ceil(min(filter_width, MAX_RADIUS)), rows outer and columns inner, each pixel carrying
// the product of the x and y tent weights; a sample's final pixel has m_tlast set. One
// multiplier is shared: it scales x, then y (input not ready), then forms one pixel weight
// per cycle while the output register can take it. A sample passes through the idle state
// that takes it, the x and y scaling states and the emit state, which issues its pixels.
// The output register lets the next sample be taken while the last pixel waits.
// Configuration writes belong to idle periods only.
module triangle_filter_splatter_top #(
	parameter int MAX_RADIUS = tfs_pkg::DEF_MAX_RADIUS,
	parameter int FRAC_BITS  = tfs_pkg::DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// sample requests
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tfs_pkg::IN_DATA_W-1:0]  s_tdata,   // pos_x, pos_y, sample_tag
	// pixel requests
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tfs_pkg::OUT_DATA_W-1:0] m_tdata,   // pixel_x, pixel_y, weight, tag_out
	output logic                           m_tlast,
	// configuration
	input  logic                           cfg_we,
	input  logic [tfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tfs_pkg::WIDTH_W-1:0]    cfg_data
);
	import tfs_pkg::*;

	localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
	localparam int OFF_W   = RAD_W + 1;
	localparam int DP_W    = FRAC_BITS + 1;
	localparam int D_W     = FRAC_BITS + OFF_W + 1;
	localparam int LIM_W   = FRAC_BITS + RAD_W;
	localparam int CMP_W   = ((WIDTH_W > LIM_W) ? WIDTH_W : LIM_W) + 1;
	localparam int TC_W    = ((WIDTH_W > D_W) ? WIDTH_W : D_W) + 1;
	localparam int MA_W    = POS_W;
	localparam int MB_W    = WIDTH_W;
	localparam int PROD_W  = MA_W + MB_W;
	localparam logic [CMP_W-1:0] LIMIT   = CMP_W'(MAX_RADIUS) << FRAC_BITS;
	localparam logic [CMP_W-1:0] ROUND   = (CMP_W'(1) << FRAC_BITS) - CMP_W'(1);
	localparam logic [DP_W-1:0]  HALF    = DP_W'(1) << (FRAC_BITS - 1);
	localparam logic [CMP_W-1:0] W_TWO   = CMP_W'(2) << FRAC_BITS;
	localparam logic [WIDTH_W-1:0] W_RESET =
		(W_TWO > CMP_W'({WIDTH_W{1'b1}})) ? {WIDTH_W{1'b1}} : W_TWO[WIDTH_W-1:0];

	// tent weight max(0, w - |dp - k|)
	function automatic logic [WIDTH_W-1:0] tent(input logic [WIDTH_W-1:0] w,
			input logic signed [DP_W-1:0] dp, input logic signed [OFF_W-1:0] k);
		logic signed [D_W-1:0] d;
		logic [D_W-1:0]        a;
		logic [TC_W-1:0]       diff;
		d    = D_W'(dp) - (D_W'(k) <<< FRAC_BITS);
		a    = d[D_W-1] ? D_W'(-d) : D_W'(d);
		diff = TC_W'(w) - TC_W'(a);
		return diff[TC_W-1] || (diff == '0) ? '0 : diff[WIDTH_W-1:0];
	endfunction

	state_t state_q, state_d;

	logic [WIDTH_W-1:0] filter_width_q;
	logic [RES_W-1:0]   res_x_q, res_y_q;

	logic [POS_W-1:0]          pos_x_q, pos_y_q;
	logic [TAG_W-1:0]          held_tag_q;
	logic [WIDTH_W-1:0]        w_q;
	logic [RAD_W-1:0]          rad_q;
	logic [RES_W-1:0]          base_px_q, base_py_q;
	logic signed [DP_W-1:0]    frac_dx_q, frac_dy_q;
	logic signed [OFF_W-1:0]   row_q, col_q;

	logic                m_tvalid_q, m_tlast_q;
	logic [PIX_W-1:0]    pixel_x_q, pixel_y_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [TAG_W-1:0]    tag_out_q;

	logic                    accept, load_out, col_end, row_end;
	logic [CMP_W-1:0]        w_sat, rad_sum;
	logic [RES_W-1:0]        res_x_sat, res_y_sat;
	logic signed [OFF_W-1:0] rad_s, neg_rad;
	logic [WIDTH_W-1:0]      row_weight, col_weight;
	logic [MA_W-1:0]         mul_a;
	logic [MB_W-1:0]         mul_b;
	logic [PROD_W-1:0]       prod;
	logic signed [DP_W-1:0]  dp_new;
	logic [WEIGHT_W-1:0]     weight_new;

	// saturated width and radius, saturated resolutions
	always_comb begin
		w_sat     = (CMP_W'(filter_width_q) > LIMIT) ? LIMIT : CMP_W'(filter_width_q);
		rad_sum   = (w_sat + ROUND) >> FRAC_BITS;
		res_x_sat = (res_x_q > RES_MAX) ? RES_MAX : res_x_q;
		res_y_sat = (res_y_q > RES_MAX) ? RES_MAX : res_y_q;
	end

	// kernel position and tents
	assign rad_s      = $signed({1'b0, rad_q});
	assign neg_rad    = -rad_s;
	assign col_end    = (col_q == rad_s);
	assign row_end    = (row_q == rad_s);
	assign row_weight = tent(w_q, frac_dy_q, row_q);
	assign col_weight = tent(w_q, frac_dx_q, col_q);

	// shared multiplier: position scaling, then pixel weights
	always_comb begin
		case (state_q)
			ST_LOC_X: begin
				mul_a = pos_x_q;
				mul_b = MB_W'(res_x_sat);
			end
			ST_LOC_Y: begin
				mul_a = pos_y_q;
				mul_b = MB_W'(res_y_sat);
			end
			default: begin
				mul_a = MA_W'(row_weight);
				mul_b = col_weight;
			end
		endcase
		prod       = PROD_W'(mul_a) * PROD_W'(mul_b);
		dp_new     = $signed({1'b0, prod[POS_W-1 -: FRAC_BITS]}) - $signed(HALF);
		weight_new = (prod[PROD_W-1:WEIGHT_W] != '0) ? {WEIGHT_W{1'b1}}
			: prod[WEIGHT_W-1:0];
	end

	// next state and handshake
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		accept   = s_tvalid && s_tready;
		load_out = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
		state_d  = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_LOC_X;
			ST_LOC_X: state_d = ST_LOC_Y;
			ST_LOC_Y: state_d = ST_EMIT;
			ST_EMIT:  if (load_out && col_end && row_end) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_width_q <= W_RESET;
			res_x_q        <= RES_RESET;
			res_y_q        <= RES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_WIDTH: filter_width_q <= cfg_data;
				REG_RES_X:        res_x_q        <= cfg_data[RES_W-1:0];
				REG_RES_Y:        res_y_q        <= cfg_data[RES_W-1:0];
				default:          ;
			endcase
		end
	end

	// kernel walk offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else begin
			case (state_q)
				ST_LOC_Y: begin
					row_q <= neg_rad;
					col_q <= neg_rad;
				end
				ST_EMIT: begin
					if (load_out) begin
						if (col_end) begin
							col_q <= neg_rad;
							row_q <= row_q + OFF_W'(1);
						end else begin
							col_q <= col_q + OFF_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// sample payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_x_q    <= s_tdata[POS_W-1:0];
			pos_y_q    <= s_tdata[2*POS_W-1:POS_W];
			held_tag_q <= s_tdata[IN_DATA_W-1:2*POS_W];
			w_q        <= w_sat[WIDTH_W-1:0];
			rad_q      <= rad_sum[RAD_W-1:0];
		end
		if (state_q == ST_LOC_X) begin
			base_px_q <= prod[POS_W+RES_W-1:POS_W];
			frac_dx_q <= dp_new;
		end
		if (state_q == ST_LOC_Y) begin
			base_py_q <= prod[POS_W+RES_W-1:POS_W];
			frac_dy_q <= dp_new;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			pixel_x_q <= PIX_W'(base_px_q) + PIX_W'(col_q);
			pixel_y_q <= PIX_W'(base_py_q) + PIX_W'(row_q);
			weight_q  <= weight_new;
			tag_out_q <= held_tag_q;
			m_tlast_q <= col_end && row_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {tag_out_q, weight_q, pixel_y_q, pixel_x_q};

	// a taken sample goes straight to x scaling
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOC_X))
		else $error("sample taken but x scaling not started");

	// kernel walk starts at the top left corner
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOC_Y) |=> (row_q == neg_rad) && (col_q == neg_rad))
		else $error("kernel walk did not start at corner");

	// offsets stay within the radius while emitting
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (col_q <= rad_s) && (col_q >= neg_rad)
			&& (row_q <= rad_s) && (row_q >= neg_rad))
		else $error("kernel offset outside radius");

	// the last pixel ends the walk
	assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && col_end && row_end) |=> (state_q == ST_IDLE) && m_tlast_q)
		else $error("last pixel did not end the sample");

endmodule
